### hw/rtl/trip_energy_distance_integrator_unit_macros.svh
// Assertion macros used by the integrator RTL file.
`ifndef TRIP_ENERGY_DISTANCE_INTEGRATOR_UNIT_MACROS_SVH
`define TRIP_ENERGY_DISTANCE_INTEGRATOR_UNIT_MACROS_SVH

// Property must hold while out of reset.
`define TEDI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TEDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tedi_pkg.sv
package tedi_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_SPEED  = 2'd0,
    CFG_MAX_INTERVAL = 2'd1,
    CFG_MIN_DISTANCE = 2'd2,
    CFG_IMPERIAL     = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] StartSpeedReset  = 16'd50;
  localparam logic [31:0] MaxIntervalReset = 32'd5000000;
  localparam logic [31:0] MinDistanceReset = 32'd100000;

  localparam logic [63:0] KnotMmPerH = 64'd1852;
  localparam logic [63:0] DistDiv    = 64'd7200000;
  localparam logic [63:0] EnergyDiv  = 64'd7200;
  localparam logic [63:0] MileMm     = 64'd1609344;
  localparam logic [63:0] MileHalf   = 64'd50000000;
  localparam logic [63:0] MileDiv    = 64'd100000000;
  localparam logic [63:0] Milli      = 64'd1000;
  localparam logic [63:0] StartScale = 64'd100000;

  // Default for the sequencer's step counter width (64 divide steps).
  localparam int unsigned StepW = 7;

  // Request to the shared multiply-divide unit: floor((a*m + add) / d), saturated.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] m;
    logic [63:0] add;
    logic [63:0] d;
  } md_req_t;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PWR,
    ST_PWR_WAIT,
    ST_CHECK,
    ST_MS,
    ST_MS_WAIT,
    ST_DIST_MUL,
    ST_DIST,
    ST_DIST_WAIT,
    ST_EN,
    ST_EN_WAIT,
    ST_ACC,
    ST_CONS,
    ST_MILLI,
    ST_MILLI_WAIT,
    ST_DECI,
    ST_DECI_WAIT,
    ST_OUT
  } state_e;

endpackage

### hw/rtl/trip_energy_distance_integrator_unit.sv
// Trip energy and distance integrator.
// Input channel: in_valid_i / in_stall_o with one port per sample field. A
// request of type 1 clears the trip; type 0 is a timestamped sample.
// Output channel: out_valid_o / out_stall_i; exactly one result per item
// carrying the trip totals and the consumption figure.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i,
// written only while the block is idle.
// Sequence: a clear, or a sample with no power figure and no consumption
// figure, goes from ST_PWR through ST_CONS to the result without the
// multiply-divide unit. A sample that integrates and reports consumption
// makes six sequential passes through the shared multiply-divide unit,
// each made of start, multiply, divide and done.
// One item is processed at a time; in_stall_o is high from acceptance
// until the result has been transferred out, so no new item is taken
// before then.
// Reset clears the trip state and loads the register defaults.
// While the receiver stalls the result is held steady and no new item is
// taken.
`include "trip_energy_distance_integrator_unit_macros.svh"
module trip_energy_distance_integrator_unit #(
  parameter int unsigned StepW = tedi_pkg::StepW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic signed [63:0]           now_us_i,
  input  logic                         gps_fix_valid_i,
  input  logic [31:0]                  speed_knots_milli_i,
  input  logic                         bms_sample_valid_i,
  input  logic [31:0]                  pack_voltage_mv_i,
  input  logic signed [15:0]           current_deci_amps_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         trip_started_o,
  output logic [63:0]                  distance_total_mm_o,
  output logic signed [63:0]           energy_total_uwh_o,
  output logic                         consumption_valid_o,
  output logic signed [31:0]           consumption_deci_wh_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tedi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import tedi_pkg::*;

  state_e state_q, state_d;

  logic [15:0] start_speed_q;
  logic [31:0] max_int_q, min_dist_q;
  logic imperial_q;

  logic started_q, started_d, anc_valid_q, anc_valid_d;
  logic [63:0] anc_time_q, anc_time_d;
  logic [31:0] anc_speed_q, anc_speed_d;
  logic signed [48:0] anc_pwr_q, anc_pwr_d;
  logic [63:0] dist_q, dist_d;
  logic signed [63:0] energy_q, energy_d;

  // Captured item.
  logic [63:0] now_q;
  logic [31:0] speed_q, volt_q;
  logic [15:0] cmag_q;
  logic cneg_q, fix_q, bms_q, req_q;

  // Working registers.
  logic signed [48:0] pwr_q, pwr_d;
  logic [63:0] ims_q, ims_d, t1_q, t1_d, t2_q, t2_d;
  logic cons_neg_q, cons_neg_d;
  logic signed [31:0] cons_q, cons_d;
  logic cons_valid_q, cons_valid_d;

  md_req_t md_req;
  logic md_start, md_done;
  logic [63:0] md_q;

  tedi_muldiv #(.StepW(StepW)) u_muldiv (
    .clk_i, .rst_ni, .start_i(md_start), .req_i(md_req), .done_o(md_done), .q_o(md_q)
  );

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // Combinational helpers.
  logic [63:0] dt;
  logic signed [49:0] psum;
  logic [49:0] pabs;
  logic [32:0] ssum;
  logic [63:0] dadd;
  logic [64:0] esum;
  logic signed [63:0] eterm;
  logic [63:0] emag;
  logic start_hit;
  logic [63:0] lim;

  always_comb begin
    dt = now_q - anc_time_q;
    psum = 50'(anc_pwr_q) + 50'(pwr_q);
    pabs = psum[49] ? 50'(-psum) : 50'(psum);
    ssum = {1'b0, anc_speed_q} + {1'b0, speed_q};
    dadd = dist_q + t1_q;
    eterm = psum[49] ? -$signed(t2_q) : $signed(t2_q);
    esum = {energy_q[63], energy_q} + {eterm[63], eterm};
    emag = energy_q[63] ? 64'(-energy_q) : 64'(energy_q);
    start_hit = (64'(speed_q) * KnotMmPerH) >= (64'(start_speed_q) * StartScale);
    lim = cons_neg_q ? 64'd2147483648 : 64'd2147483647;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_acc) state_d = ST_PWR;
      ST_PWR: begin
        if (req_q) state_d = ST_CONS;
        else if (!(started_q || (fix_q && start_hit)) || !fix_q || !bms_q ||
                 volt_q == '0) state_d = ST_CONS;
        else state_d = ST_PWR_WAIT;
      end
      ST_PWR_WAIT:   if (md_done) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!anc_valid_q || ($signed(now_q) <= $signed(anc_time_q)) ||
            dt > 64'(max_int_q)) state_d = ST_CONS;
        else state_d = ST_MS;
      end
      ST_MS:         state_d = ST_MS_WAIT;
      ST_MS_WAIT:    if (md_done) state_d = ST_DIST_MUL;
      ST_DIST_MUL:   state_d = ST_DIST;
      ST_DIST:       state_d = ST_DIST_WAIT;
      ST_DIST_WAIT:  if (md_done) state_d = ST_EN;
      ST_EN:         state_d = ST_EN_WAIT;
      ST_EN_WAIT:    if (md_done) state_d = ST_ACC;
      ST_ACC:        state_d = ST_CONS;
      ST_CONS: begin
        if (dist_q >= 64'(min_dist_q) && dist_q != '0) state_d = ST_MILLI;
        else state_d = ST_OUT;
      end
      ST_MILLI:      state_d = ST_MILLI_WAIT;
      ST_MILLI_WAIT: if (md_done) state_d = ST_DECI;
      ST_DECI:       state_d = ST_DECI_WAIT;
      ST_DECI_WAIT:  if (md_done) state_d = ST_OUT;
      ST_OUT:        if (!out_stall_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    md_start = 1'b0;
    md_req = '{a: 64'(volt_q), m: 64'(cmag_q), add: '0, d: 64'd10};
    started_d = started_q; anc_valid_d = anc_valid_q; anc_time_d = anc_time_q;
    anc_speed_d = anc_speed_q; anc_pwr_d = anc_pwr_q; dist_d = dist_q;
    energy_d = energy_q; pwr_d = pwr_q; ims_d = ims_q; t1_d = t1_q; t2_d = t2_q;
    cons_neg_d = cons_neg_q; cons_d = cons_q; cons_valid_d = cons_valid_q;
    unique case (state_q)
      ST_PWR: begin
        if (req_q) begin
          started_d = 1'b0; anc_valid_d = 1'b0; anc_time_d = '0; anc_speed_d = '0;
          anc_pwr_d = '0; dist_d = '0; energy_d = '0;
        end else begin
          if (fix_q && start_hit) started_d = 1'b1;
          if (!(started_q || (fix_q && start_hit)) || !fix_q || !bms_q ||
              volt_q == '0) anc_valid_d = 1'b0;
          else md_start = 1'b1;
        end
      end
      ST_PWR_WAIT: begin
        if (md_done) pwr_d = cneg_q ? $signed(md_q[48:0]) : -$signed(md_q[48:0]);
      end
      ST_CHECK: begin
        anc_time_d = now_q; anc_speed_d = speed_q; anc_pwr_d = pwr_q;
        anc_valid_d = 1'b1;
        // Keep the old anchor for the integration path; it is replaced in ST_ACC.
        if (anc_valid_q && ($signed(now_q) > $signed(anc_time_q)) &&
            dt <= 64'(max_int_q)) begin
          anc_time_d = anc_time_q; anc_speed_d = anc_speed_q; anc_pwr_d = anc_pwr_q;
        end
      end
      ST_MS: begin
        md_start = 1'b1;
        md_req = '{a: dt, m: 64'd1, add: '0, d: Milli};
      end
      ST_MS_WAIT: if (md_done) ims_d = md_q;
      ST_DIST_MUL: t1_d = 64'(ssum) * KnotMmPerH;
      ST_DIST: begin
        md_start = 1'b1;
        md_req = '{a: t1_q, m: ims_q, add: '0, d: DistDiv};
      end
      ST_DIST_WAIT: if (md_done) t1_d = md_q;
      ST_EN: begin
        md_start = 1'b1;
        md_req = '{a: 64'(pabs), m: ims_q, add: '0, d: EnergyDiv};
      end
      ST_EN_WAIT: if (md_done) t2_d = md_q;
      ST_ACC: begin
        dist_d = (dadd < dist_q) ? '1 : dadd;
        if (esum[64] != esum[63])
          energy_d = esum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else energy_d = esum[63:0];
        anc_time_d = now_q; anc_speed_d = speed_q; anc_pwr_d = pwr_q;
      end
      ST_CONS: begin
        cons_valid_d = dist_q >= 64'(min_dist_q);
        cons_d = '0;
        cons_neg_d = energy_q[63];
      end
      ST_MILLI: begin
        md_start = 1'b1;
        md_req = '{a: emag, m: Milli, add: {1'b0, dist_q[63:1]}, d: dist_q};
      end
      ST_MILLI_WAIT: if (md_done) t1_d = md_q;
      ST_DECI: begin
        md_start = 1'b1;
        if (imperial_q) md_req = '{a: t1_q, m: MileMm, add: MileHalf, d: MileDiv};
        else md_req = '{a: t1_q, m: 64'd1, add: 64'd50, d: 64'd100};
      end
      ST_DECI_WAIT: begin
        if (md_done) begin
          t2_d = (md_q > lim) ? lim : md_q;
          cons_d = cons_neg_q ? 32'(-t2_d) : 32'(t2_d);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_speed_q <= StartSpeedReset;
      max_int_q <= MaxIntervalReset;
      min_dist_q <= MinDistanceReset;
      imperial_q <= 1'b0;
      started_q <= 1'b0; anc_valid_q <= 1'b0; anc_time_q <= '0; anc_speed_q <= '0;
      anc_pwr_q <= '0; dist_q <= '0; energy_q <= '0;
    end else begin
      state_q <= state_d;
      started_q <= started_d; anc_valid_q <= anc_valid_d; anc_time_q <= anc_time_d;
      anc_speed_q <= anc_speed_d; anc_pwr_q <= anc_pwr_d; dist_q <= dist_d;
      energy_q <= energy_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_START_SPEED:  start_speed_q <= cfg_data_i[15:0];
          CFG_MAX_INTERVAL: max_int_q <= cfg_data_i;
          CFG_MIN_DISTANCE: min_dist_q <= cfg_data_i;
          CFG_IMPERIAL:     imperial_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_type_i; now_q <= now_us_i; fix_q <= gps_fix_valid_i;
      speed_q <= speed_knots_milli_i; bms_q <= bms_sample_valid_i;
      volt_q <= pack_voltage_mv_i;
      cneg_q <= current_deci_amps_i[15];
      cmag_q <= current_deci_amps_i[15] ? 16'(-current_deci_amps_i)
                                        : 16'(current_deci_amps_i);
    end
    pwr_q <= pwr_d; ims_q <= ims_d; t1_q <= t1_d; t2_q <= t2_d;
    cons_neg_q <= cons_neg_d; cons_q <= cons_d; cons_valid_q <= cons_valid_d;
  end

  assign trip_started_o = started_q;
  assign distance_total_mm_o = dist_q;
  assign energy_total_uwh_o = energy_q;
  assign consumption_valid_o = cons_valid_q;
  assign consumption_deci_wh_o = cons_q;

  `TEDI_ASSERT(a_busy_excl, clk_i, rst_ni, !(out_valid_o && cfg_ready_o), "out while idle")
  `TEDI_ASSERT(a_cons_zero, clk_i, rst_ni, !out_valid_o || consumption_valid_o || consumption_deci_wh_o == '0, "cons without valid")
  `TEDI_ASSERT_NEXT(a_take, clk_i, rst_ni, in_acc, in_stall_o, "not busy after accept")
  `TEDI_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(distance_total_mm_o), "result changed under stall")

endmodule

### hw/rtl/tedi_muldiv.sv
// Computes floor((a*m + add) / d) saturated to 64 bits. The 64x64 product is
// built from four 32x32 partial products, then a restoring divide takes
// one quotient bit per cycle.
module tedi_muldiv #(
  parameter int unsigned StepW = tedi_pkg::StepW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tedi_pkg::md_req_t req_i,
  output logic             done_o,
  output logic [63:0]      q_o
);
  import tedi_pkg::*;

  md_state_e state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  md_req_t req_q, req_d;
  logic [127:0] prod_q, prod_d;
  logic [63:0] rem_q, rem_d, lo_q, lo_d, quo_q, quo_d;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh, sum;
  logic [64:0] rem_sh;
  logic ovf;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    begin pa = req_q.a[31:0];  pb = req_q.m[31:0];  end
      2'd1:    begin pa = req_q.a[31:0];  pb = req_q.m[63:32]; end
      2'd2:    begin pa = req_q.a[63:32]; pb = req_q.m[31:0];  end
      default: begin pa = req_q.a[63:32]; pb = req_q.m[63:32]; end
    endcase
    pp = 64'(pa) * 64'(pb);
    unique case (cnt_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd1,
      2'd2:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  assign sum = prod_q + pp_sh;
  assign rem_sh = {rem_q, lo_q[63]};
  assign ovf = (prod_q[127:64] >= req_q.d);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    req_d = req_q;
    prod_d = prod_q;
    rem_d = rem_q;
    lo_d = lo_q;
    quo_d = quo_q;
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          prod_d = {64'd0, req_i.add};
          cnt_d = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_d = sum;
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q[1:0] == 2'd3) begin
          state_d = MD_DIV;
          cnt_d = '0;
        end
      end
      MD_DIV: begin
        if (cnt_q == '0 && ovf) begin
          quo_d = '1;
          state_d = MD_DONE;
        end else begin
          if (cnt_q == '0) begin
            rem_d = prod_q[127:64];
            lo_d = prod_q[63:0];
            quo_d = '0;
          end
          cnt_d = cnt_q + StepW'(1);
          state_d = MD_DIV;
          if (cnt_q != '0) begin
            lo_d = {lo_q[62:0], 1'b0};
            if (rem_sh >= {1'b0, req_q.d}) begin
              rem_d = 64'(rem_sh - {1'b0, req_q.d});
              quo_d = {quo_q[62:0], 1'b1};
            end else begin
              rem_d = rem_sh[63:0];
              quo_d = {quo_q[62:0], 1'b0};
            end
            if (cnt_q == StepW'(64)) state_d = MD_DONE;
          end
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    prod_q <= prod_d;
    rem_q <= rem_d;
    lo_q <= lo_d;
    quo_q <= quo_d;
  end

  assign done_o = (state_q == MD_DONE);
  assign q_o = quo_q;

endmodule
